### rtl/assert_macros.svh
// Assertion macros for the RTL files; iac_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/iac_pkg.sv
// Package with types, codes and constants of the ignition angle calculator.
package iac_pkg;
    localparam int DEF_CHANNELS = 8;
    localparam logic [2:0] MODE_SINGLE = 3'd0;
    localparam logic [2:0] MODE_WASTED = 3'd1;
    localparam logic [2:0] MODE_COP = 3'd2;
    localparam logic [2:0] MODE_SEQ = 3'd3;
    localparam logic [2:0] MODE_ROTARY = 3'd4;
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_CYL = 3'd1;
    localparam logic [2:0] REG_STROKE = 3'd2;
    localparam logic [2:0] REG_ODD = 3'd3;
    localparam logic [2:0] REG_ODDANG = 3'd4;
    localparam logic [2:0] REG_TRIMS = 3'd5;
    localparam logic [9:0] ANG_720 = 10'd720;
    localparam logic [9:0] ANG_360 = 10'd360;
    localparam logic [9:0] ANG_180 = 10'd180;

    typedef struct packed {
        logic load;
        logic step;
        logic derive;
    } iac_cmd_t;

    typedef struct packed {
        logic last_ch;
        logic derive_done;
        logic cfg_hit;
    } iac_status_t;
endpackage

### rtl/iac_ctrl.sv
// Controller state machine of the ignition angle calculator.
module iac_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  iac_pkg::iac_status_t status,
    output iac_pkg::iac_cmd_t   cmd
);
    import iac_pkg::*;

    typedef enum logic [3:0] {
        ST_DERIVE = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DERIVE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_axis_tvalid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_DERIVE:
            begin
                cmd.derive = 1'b1;
                if (status.derive_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (status.cfg_hit)
                    begin
                        state_next = ST_DERIVE;
                    end
                end
                else if (s_axis_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    cmd.step = 1'b1;
                    state_next = status.last_ch ? ST_IDLE : ST_CALC;
                end
            end
            default: state_next = ST_DERIVE;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_no_in_busy, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_load_calc, clk, rst_n, cmd.load, state_reg == ST_CALC)
    `ASSERT_NEXT(a_last_idle, clk, rst_n, cmd.step && status.last_ch, state_reg == ST_IDLE)
endmodule

### rtl/iac_dp.sv
// Datapath of the ignition angle calculator: derivation, sync switch, angles.
module iac_dp
#(
    parameter int CHANNELS = iac_pkg::DEF_CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [31:0]          in_data,
    input  iac_pkg::iac_cmd_t    cmd,
    output iac_pkg::iac_status_t status,
    output logic [31:0]          out_data,
    output logic                 out_last
);
    import iac_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OVW = 10 * CHANNELS + 40;

    logic [2:0]  mode_reg;
    logic [3:0]  cyl_reg;
    logic        stroke_reg, odd_reg;
    logic [29:0] oddang_reg;
    logic [63:0] trims_reg;

    logic [2:0]  emode_reg;
    logic [3:0]  ecyl_reg;
    logic        odd_eff_reg;
    logic [9:0]  cycle_reg;
    logic [3:0]  act_reg;
    logic [9:0]  inter_reg;
    logic [2:0]  dstep_reg;

    logic signed [7:0] base_reg;
    logic [9:0]  dwell_reg;
    logic [7:0]  split_reg;
    logic        fseq_reg;
    logic        rot_mode;
    logic [2:0]  ch_reg;
    logic signed [11:0] spark_reg, charge_reg;
    logic signed [11:0] lead_reg [2];
    logic [OVW-1:0] odd_vec;

    assign odd_vec = OVW'({oddang_reg, 10'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_WASTED;
            cyl_reg    <= 4'd4;
            stroke_reg <= 1'b1;
            odd_reg    <= 1'b0;
            oddang_reg <= '0;
            trims_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_CYL:    cyl_reg    <= cfg_data[3:0];
                REG_STROKE: stroke_reg <= cfg_data[0];
                REG_ODD:    odd_reg    <= cfg_data[0];
                REG_ODDANG: oddang_reg <= cfg_data[29:0];
                REG_TRIMS:  trims_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [3:0] n;
    logic [2:0] m;
    logic       fs, odd;
    logic [9:0] cyc_d;
    logic [3:0] act_d;
    always_comb
    begin
        n = (cyl_reg == 4'd0) ? 4'd1 : cyl_reg;
        m = (mode_reg > MODE_ROTARY) ? MODE_WASTED : mode_reg;
        fs = stroke_reg;
        if (m == MODE_SEQ && (32'(n) > CHANNELS || !fs)) m = MODE_WASTED;
        if (m == MODE_ROTARY && n != 4'd4) m = MODE_WASTED;
        if (m == MODE_COP && n != 4'd4 && n != 4'd6 && n != 4'd8) m = MODE_WASTED;
        odd = odd_reg && (n <= 4'd4);
        if (m == MODE_ROTARY)
        begin
            fs = 1'b1;
            odd = 1'b0;
        end
        cyc_d = (m == MODE_SEQ || (fs && m == MODE_SINGLE && (n == 4'd3 || n == 4'd5)))
            ? ANG_720 : ANG_360;
        if (n < 4'd4 || n == 4'd5 || odd || m == MODE_SEQ || m == MODE_ROTARY) act_d = n;
        else act_d = n >> 1;
        if (32'(act_d) > CHANNELS) act_d = 4'(CHANNELS);
        if (act_d == 4'd0) act_d = 4'd1;
    end

    logic [9:0] inter_d;
    always_comb
    begin
        case (act_d)
            4'd1: inter_d = cyc_d;
            4'd2: inter_d = cyc_d >> 1;
            4'd3: inter_d = (cyc_d == ANG_720) ? 10'd240 : 10'd120;
            4'd4: inter_d = cyc_d >> 2;
            4'd5: inter_d = (cyc_d == ANG_720) ? 10'd144 : 10'd72;
            4'd6: inter_d = (cyc_d == ANG_720) ? 10'd120 : 10'd60;
            4'd7: inter_d = (cyc_d == ANG_720) ? 10'd102 : 10'd51;
            default: inter_d = cyc_d >> 3;
        endcase
    end

    logic [9:0] offs_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstep_reg <= '0;
        end
        else if (cmd.derive)
        begin
            dstep_reg <= (dstep_reg == 3'd2) ? 3'd0 : dstep_reg + 3'd1;
        end
    end
    assign status.derive_done = (dstep_reg == 3'd2);
    assign status.cfg_hit = (cfg_index <= REG_TRIMS);

    always_ff @(posedge clk)
    begin
        if (cmd.derive && dstep_reg == 3'd0)
        begin
            emode_reg   <= m;
            ecyl_reg    <= n;
            odd_eff_reg <= odd;
            cycle_reg   <= cyc_d;
            act_reg     <= act_d;
            inter_reg   <= inter_d;
        end
        if (cmd.derive && dstep_reg == 3'd1)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (odd_eff_reg)
                    offs_reg[i] <= odd_vec[10*i +: 10];
                else if (emode_reg == MODE_ROTARY)
                    offs_reg[i] <= (i == 1 || i == 3) ? ANG_180 : 10'd0;
                else
                    offs_reg[i] <= 10'(i * inter_reg);
            end
        end
        if (cmd.load)
        begin
            base_reg  <= signed'(in_data[7:0]);
            dwell_reg <= in_data[17:8];
            split_reg <= in_data[25:18];
            ch_reg    <= '0;
        end
        if (cmd.step)
        begin
            ch_reg <= ch_reg + 3'd1;
        end
        if (cmd.load && emode_reg == MODE_SEQ)
        begin
            if (in_data[27:26] == 2'd2 && cycle_reg != ANG_720)
            begin
                if (in_data[28] && (ecyl_reg == 4'd4 || ecyl_reg == 4'd6 || ecyl_reg == 4'd8))
                begin
                    cycle_reg <= ANG_720;
                    act_reg <= (32'(ecyl_reg) < CHANNELS) ? ecyl_reg : 4'(CHANNELS);
                end
            end
            else if ((ecyl_reg == 4'd4 || ecyl_reg == 4'd6 || ecyl_reg == 4'd8)
                     && in_data[27:26] == 2'd1 && cycle_reg != ANG_360 && in_data[28])
            begin
                cycle_reg <= ANG_360;
                act_reg <= ecyl_reg >> 1;
            end
        end
        if (cmd.load)
        begin
            fseq_reg <= (emode_reg == MODE_SEQ) && (in_data[27:26] == 2'd2);
        end
    end

    assign rot_mode = (emode_reg == MODE_ROTARY) && (act_reg == 4'd4) && (CHANNELS >= 4);

    logic signed [9:0]  adv;
    logic signed [8:0]  adv_sum;
    logic signed [11:0] cyc_s, off_s, sp, ch_a, rt, rc;
    logic signed [12:0] rsum;
    logic signed [12:0] cyc13, rc0, rc1, rc2, rc3;
    logic [CW-1:0]      idx;
    always_comb
    begin
        idx = CW'(ch_reg);
        adv_sum = 9'(base_reg) + 9'(signed'(trims_reg[8*ch_reg +: 8]));
        if (fseq_reg)
        begin
            if (adv_sum > 9'sd127) adv = 10'sd127;
            else if (adv_sum < -9'sd128) adv = -10'sd128;
            else adv = 10'(adv_sum);
        end
        else
        begin
            adv = 10'(base_reg);
        end
        cyc_s = signed'({2'b00, cycle_reg});
        off_s = signed'({2'b00, offs_reg[idx]});
        sp = ((off_s == 12'sd0) ? cyc_s : off_s) - 12'(adv);
        if (sp > cyc_s) sp = sp - cyc_s;
        if (sp > signed'({2'b00, dwell_reg})) ch_a = sp - signed'({2'b00, dwell_reg});
        else ch_a = sp + cyc_s - signed'({2'b00, dwell_reg});
        rsum = 13'(lead_reg[ch_reg[0]]) + 13'(split_reg);
        if (rsum < 13'sd0) rsum = rsum + 13'(cyc_s);
        else if (rsum >= 13'(cyc_s)) rsum = rsum - 13'(cyc_s);
        if (rsum >= 13'(cyc_s)) rsum = rsum - 13'(cyc_s);
        rt = 12'(rsum);
        cyc13 = 13'(cyc_s);
        rc0 = 13'(rt) - signed'({3'b000, dwell_reg});
        rc1 = rc0 + cyc13;
        rc2 = rc0 + (cyc13 <<< 1);
        rc3 = rc1 + (cyc13 <<< 1);
        if (rc0 >= 13'sd0) rc = 12'(rc0);
        else if (rc1 >= 13'sd0) rc = 12'(rc1);
        else if (rc2 >= 13'sd0) rc = 12'(rc2);
        else rc = 12'(rc3);
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.load && !cmd.step && !cmd.derive)
        begin
            if (rot_mode && ch_reg[1])
            begin
                spark_reg  <= rt;
                charge_reg <= rc;
            end
            else
            begin
                spark_reg  <= sp;
                charge_reg <= ch_a;
                if (!ch_reg[1]) lead_reg[ch_reg[0]] <= sp;
            end
        end
    end

    assign status.last_ch = ({1'b0, ch_reg} + 4'd1 == act_reg);
    assign out_last = status.last_ch;
    assign out_data = {6'b0, charge_reg, spark_reg[10:0], ch_reg};
endmodule

### rtl/ignition_angle_calculator_unit.sv
// Top level of the ignition angle calculator.
// Channels: s_axis carries one engine event per transaction, tdata
// {coils_idle, sync_state, rotary_split, dwell_angle, base_advance}.
// m_axis returns one transaction per active channel, tdata
// {charge_angle, spark_angle, channel}, tlast on the final channel.
// cfg writes one register by index 0..5 while the block is idle.
// After an event is accepted, each channel result is computed in ST_CALC
// and offered in ST_OUT; the channels pass in turn through the shared
// angle unit. A write to registers 0..5 starts a new layout derivation.
// Reset loads the default registers and derives the channel layout before
// the input is ready. A stalled m_axis holds the current result until
// taken; no new event is accepted until the last result of the current
// event has been delivered.
module ignition_angle_calculator_unit
#(
    parameter int CHANNELS = iac_pkg::DEF_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // base_advance, dwell_angle, rotary_split, sync_state, coils_idle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // channel, spark_angle, charge_angle
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import iac_pkg::*;

    iac_cmd_t    cmd;
    iac_status_t status;

    iac_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .status(status), .cmd(cmd)
    );

    iac_dp #(.CHANNELS(CHANNELS)) u_dp
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata), .cmd(cmd), .status(status),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule

### tb/ignition_angle_calculator_unit_checker.sv
// Checker: watches the event, result and configuration channels, predicts and compares.
`timescale 1ns / 100ps
module ignition_angle_calculator_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import iac_pkg::*;

    localparam int NCH = 8;

    typedef struct packed {
        logic        last;
        logic [11:0] charge;
        logic [10:0] spark;
        logic [2:0]  channel;
    } firing_t;

    logic [2:0]  reg_mode;
    logic [3:0]  reg_cyl;
    logic        reg_stroke;
    logic        reg_odd;
    logic [29:0] reg_oddang;
    logic [63:0] reg_trims;

    int          eff_mode;
    int          eff_cyl;
    int          cycle_deg;
    int          active_ch;
    int          ch_offset [NCH];
    firing_t     firing_q [$];

    function automatic int wrap_deg(int x);
        int r;
        r = x % cycle_deg;
        if (r < 0)
            r += cycle_deg;
        return r;
    endfunction

    function automatic int spark_deg(int ch, int adv);
        int a;
        a = (ch_offset[ch] == 0 ? cycle_deg : ch_offset[ch]) - adv;
        if (a > cycle_deg)
            a -= cycle_deg;
        return a;
    endfunction

    function automatic int charge_deg(int sp, int dw);
        return (sp > dw) ? sp - dw : sp + cycle_deg - dw;
    endfunction

    task automatic derive_layout();
        int  n;
        int  m;
        bit  fs;
        bit  odd;
        int  inter;
        n = (reg_cyl == 0) ? 1 : int'(reg_cyl);
        m = int'(reg_mode);
        fs = reg_stroke;
        if (m > 4)
            m = MODE_WASTED;
        if (m == MODE_SEQ && (n > NCH || !fs))
            m = MODE_WASTED;
        if (m == MODE_ROTARY && n != 4)
            m = MODE_WASTED;
        if (m == MODE_COP && n != 4 && n != 6 && n != 8)
            m = MODE_WASTED;
        odd = reg_odd && (n <= 4);
        if (m == MODE_ROTARY)
        begin
            fs = 1;
            odd = 0;
        end
        eff_mode = m;
        eff_cyl = n;
        cycle_deg = (m == MODE_SEQ || (fs && m == MODE_SINGLE && (n == 3 || n == 5)))
                    ? 720 : 360;
        if (n < 4 || n == 5 || odd || m == MODE_SEQ || m == MODE_ROTARY)
            active_ch = n;
        else
            active_ch = n / 2;
        if (active_ch > NCH)
            active_ch = NCH;
        if (active_ch == 0)
            active_ch = 1;
        for (int i = 0; i < NCH; i++)
            ch_offset[i] = 0;
        if (odd)
        begin
            for (int i = 0; i < 3; i++)
                ch_offset[i + 1] = int'(reg_oddang[10 * i +: 10]);
        end
        else if (m == MODE_ROTARY)
        begin
            ch_offset[1] = 180;
            ch_offset[3] = 180;
        end
        else
        begin
            inter = cycle_deg / active_ch;
            for (int i = 0; i < NCH; i++)
                ch_offset[i] = (i * inter) & 10'h3FF;
        end
    endtask

    task automatic predict_event(logic [31:0] d);
        int      base;
        int      dwell;
        int      split;
        int      sync;
        bit      idle;
        bit      switchable;
        bit      full_seq;
        int      adv;
        int      sp [NCH];
        int      cg [NCH];
        firing_t f;
        base = int'($signed(d[7:0]));
        dwell = int'(d[17:8]);
        split = int'(d[25:18]);
        sync = int'(d[27:26]);
        idle = d[28];
        switchable = (eff_cyl == 4 || eff_cyl == 6 || eff_cyl == 8);
        if (eff_mode == MODE_SEQ && sync == 2 && cycle_deg != 720)
        begin
            if (idle && switchable)
            begin
                cycle_deg = 720;
                active_ch = eff_cyl < NCH ? eff_cyl : NCH;
            end
        end
        else if (eff_mode == MODE_SEQ && switchable && sync == 1 && cycle_deg != 360)
        begin
            if (idle)
            begin
                cycle_deg = 360;
                active_ch = eff_cyl / 2;
            end
        end
        if (active_ch == 0)
            active_ch = 1;
        if (active_ch > NCH)
            active_ch = NCH;
        full_seq = (eff_mode == MODE_SEQ && sync == 2);
        if (active_ch == 4 && eff_mode == MODE_ROTARY)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sp[i] = spark_deg(i, base);
                cg[i] = charge_deg(sp[i], dwell);
                sp[i + 2] = wrap_deg(sp[i] + split);
                cg[i + 2] = wrap_deg(sp[i + 2] - dwell);
            end
        end
        else
        begin
            for (int i = 0; i < active_ch; i++)
            begin
                adv = base;
                if (full_seq)
                begin
                    adv = base + int'($signed(reg_trims[8 * i +: 8]));
                    if (adv > 127)
                        adv = 127;
                    if (adv < -128)
                        adv = -128;
                end
                sp[i] = spark_deg(i, adv);
                cg[i] = charge_deg(sp[i], dwell);
            end
        end
        for (int i = 0; i < active_ch; i++)
        begin
            f.channel = i[2:0];
            f.spark = sp[i][10:0];
            f.charge = cg[i][11:0];
            f.last = (i + 1 == active_ch);
            firing_q.push_back(f);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_mode = MODE_WASTED;
            reg_cyl = 4'd4;
            reg_stroke = 1'b1;
            reg_odd = 1'b0;
            reg_oddang = '0;
            reg_trims = '0;
            firing_q.delete();
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
            derive_layout();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                firing_t got;
                firing_t exp_f;
                got = {m_axis_tlast, m_axis_tdata[25:0]};
                result_count <= result_count + 1;
                if (firing_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_f = firing_q.pop_front();
                    if (got !== exp_f || m_axis_tdata[31:26] !== 6'd0)
                    begin
                        $display("%0t: mismatch ch/spark/charge/last expected %0d/%0d/%0d/%0b",
                                 $time, exp_f.channel, $signed(exp_f.spark),
                                 $signed(exp_f.charge), exp_f.last);
                        $display("%0t:          actual %0d/%0d/%0d/%0b tdata %h", $time,
                                 got.channel, $signed(got.spark), $signed(got.charge),
                                 got.last, m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_event(s_axis_tdata);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:   reg_mode = cfg_data[2:0];
                    REG_CYL:    reg_cyl = cfg_data[3:0];
                    REG_STROKE: reg_stroke = cfg_data[0];
                    REG_ODD:    reg_odd = cfg_data[0];
                    REG_ODDANG: reg_oddang = cfg_data[29:0];
                    REG_TRIMS:  reg_trims = cfg_data;
                    default: ;
                endcase
                if (cfg_index <= REG_TRIMS)
                    derive_layout();
            end
            pending_count <= firing_q.size();
        end
    end
endmodule

### tb/ignition_angle_calculator_unit_tb.sv
// Testbench top: drives engine events and register writes, gives the verdict.
`timescale 1ns / 100ps
module ignition_angle_calculator_unit_tb;
    import iac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          cycles = 0;
    int          events_sent;
    int          settings_run;

    ignition_angle_calculator_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ignition_angle_calculator_unit_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_event(logic signed [7:0] adv, logic [9:0] dwell, logic [7:0] split,
                              logic [1:0] sync, logic idle);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, idle, sync, split, dwell, adv};
        do
            @(posedge clk);
        while (!s_axis_tready);
        events_sent++;
    endtask

    task automatic send_random_event();
        logic [9:0] dwell;
        dwell = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(720));
        send_event(8'($urandom), dwell, 8'($urandom), 2'($urandom_range(3)),
                   1'($urandom));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(logic [2:0] mode, logic [3:0] cyl, logic stroke, logic odd,
                                logic [29:0] oddang, logic [63:0] trims);
        write_reg(REG_MODE, {61'd0, mode});
        write_reg(REG_CYL, {60'd0, cyl});
        write_reg(REG_STROKE, {63'd0, stroke});
        write_reg(REG_ODD, {63'd0, odd});
        write_reg(REG_ODDANG, {34'd0, oddang});
        write_reg(REG_TRIMS, trims);
        settings_run++;
    endtask

    task automatic random_setting();
        logic [2:0] mode;
        logic [3:0] cyl;
        mode = 3'($urandom);
        cyl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8));
        if ($urandom_range(2) == 0)
            mode = ($urandom_range(1) == 0) ? MODE_SEQ : MODE_ROTARY;
        if (mode == MODE_ROTARY && $urandom_range(1) == 0)
            cyl = 4'd4;
        load_setting(mode, cyl, 1'($urandom_range(3) != 0), 1'($urandom),
                     {10'($urandom_range(720)), 10'($urandom_range(720)),
                      10'($urandom_range(720))},
                     {$urandom, $urandom});
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 52;
        events_sent = 0;
        settings_run = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(8'sd127, 10'd0, 8'd0, 2'd0, 1'b1);
        send_event(-8'sd128, 10'd720, 8'd255, 2'd2, 1'b0);
        send_event(8'sd0, 10'd1023, 8'd128, 2'd3, 1'b1);

        load_setting(MODE_SEQ, 4'd8, 1'b1, 1'b0, 30'h3FFFFFFF, 64'h807F_0180_7F01_FF80);
        send_event(8'sd100, 10'd300, 8'd0, 2'd2, 1'b1);
        send_event(-8'sd100, 10'd700, 8'd0, 2'd2, 1'b1);
        send_event(8'sd10, 10'd0, 8'd0, 2'd1, 1'b0);
        send_event(8'sd10, 10'd100, 8'd0, 2'd1, 1'b1);
        send_event(8'sd10, 10'd100, 8'd0, 2'd2, 1'b0);
        send_event(8'sd10, 10'd100, 8'd0, 2'd2, 1'b1);

        load_setting(MODE_ROTARY, 4'd4, 1'b0, 1'b1, 30'h0, 64'h0);
        send_event(8'sd127, 10'd720, 8'd255, 2'd0, 1'b1);
        send_event(-8'sd128, 10'd0, 8'd200, 2'd2, 1'b0);

        load_setting(3'd7, 4'd0, 1'b0, 1'b0, 30'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(8'sd5, 10'd5, 8'd1, 2'd2, 1'b1);

        load_setting(MODE_SINGLE, 4'd15, 1'b1, 1'b0, 30'h0, 64'h0);
        send_event(8'sd0, 10'd360, 8'd0, 2'd0, 1'b1);

        load_setting(MODE_WASTED, 4'd3, 1'b1, 1'b1, {10'd720, 10'd1023, 10'd0}, 64'h0);
        send_event(-8'sd1, 10'd1, 8'd0, 2'd0, 1'b1);
        send_event(8'sd127, 10'd719, 8'd0, 2'd0, 1'b1);

        load_setting(MODE_SINGLE, 4'd5, 1'b1, 1'b0, 30'h0, 64'h0);
        send_event(8'sd20, 10'd400, 8'd0, 2'd0, 1'b0);

        load_setting(MODE_COP, 4'd6, 1'b0, 1'b0, 30'h0, 64'h0);
        send_event(8'sd30, 10'd50, 8'd0, 2'd1, 1'b1);

        fork
            begin
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (150)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
            repeat (4)
                send_random_event();
        join

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 38 : 0;
            for (int s = 0; s < 5; s++)
            begin
                random_setting();
                for (int k = 0; k < 16; k++)
                    send_random_event();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        $display("covered %0d engine events and %0d results over %0d register settings",
                 events_sent, result_count, settings_run);
        $display("modes single to rotary, sync switching, trims, odd-fire and long back-pressure");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/iac_pkg.sv
rtl/iac_ctrl.sv
rtl/iac_dp.sv
rtl/ignition_angle_calculator_unit.sv
tb/ignition_angle_calculator_unit_checker.sv
tb/ignition_angle_calculator_unit_tb.sv
